// File: rtl/pmd_pkg.sv
// Shared types, constants and register indexes for the PID motor drive block.
`timescale 1ns / 1ps

package pmd_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_TARGET_ANGLE  = 3'd0,
        CFG_GAIN_PROP     = 3'd1,
        CFG_GAIN_INTEG    = 3'd2,
        CFG_GAIN_DERIV    = 3'd3,
        CFG_STARTUP_TICKS = 3'd4,
        CFG_PWM_PERIOD    = 3'd5
    } cfg_idx_t;

    localparam int CFG_DATA_W = 32;

    localparam logic signed [15:0] RST_TARGET_ANGLE  = 16'sd0;
    localparam logic [31:0]        RST_GAIN_PROP     = 32'd3748052;
    localparam logic [31:0]        RST_GAIN_INTEG    = 32'd450;
    localparam logic [31:0]        RST_GAIN_DERIV    = 32'd56220780;
    localparam logic [15:0]        RST_STARTUP_TICKS = 16'd500;
    localparam logic [15:0]        RST_PWM_PERIOD    = 16'd6000;

    localparam int QUEUE_DEPTH_DEF = 4;

    // Full duty is 2^32 in Q32; the integral term is limited to +-2^61.
    localparam logic [63:0]        FULL_DUTY_Q32 = 64'h0000_0001_0000_0000;
    localparam logic signed [63:0] TERM_LIMIT    = 64'sh2000_0000_0000_0000;

    // One classified control tick as it travels from front to back.
    typedef struct packed {
        logic               run;
        logic signed [16:0] err;
    } tick_item_t;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_MUL  = 2'd1,
        ST_ADD  = 2'd2,
        ST_MAG  = 2'd3
    } back_state_t;

    // Finished controller output, before the duty scaling.
    typedef struct packed {
        logic        run;
        logic        dir;
        logic        sat;
        logic        full;
        logic [31:0] mag_lo;
    } fin_item_t;

endpackage

// File: rtl/pid_motor_drive_antiwindup.sv
// Top level of the PID motor drive: configuration registers, front end, queue and back end.
// The back end works on one item at a time, stepping through its sequencer (pop, multiply,
// add, magnitude) and taking no new item until it is through with the last one, since each
// tick's integrator update needs the last saturation flag; the magnitude step waits for room.
// The input queue takes items every cycle until it fills; the output register frees the back end.
// Reset is asynchronous, active low, loads the default gains and clears the control state only.
`timescale 1ns / 1ps

module pid_motor_drive_antiwindup
    import pmd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [2:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [15:0]    angle_centideg,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  direction,
    output logic [15:0]           duty,
    output logic                  running,
    output logic                  saturated
);

    logic signed [15:0] target_angle_reg;
    logic [31:0]        gain_prop_reg;
    logic [31:0]        gain_integ_reg;
    logic [31:0]        gain_deriv_reg;
    logic [15:0]        startup_ticks_reg;
    logic [15:0]        pwm_period_reg;

    logic       push;
    logic       q_full;
    logic       q_not_empty;
    logic       q_pop;
    tick_item_t front_item;
    tick_item_t q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_angle_reg  <= RST_TARGET_ANGLE;
            gain_prop_reg     <= RST_GAIN_PROP;
            gain_integ_reg    <= RST_GAIN_INTEG;
            gain_deriv_reg    <= RST_GAIN_DERIV;
            startup_ticks_reg <= RST_STARTUP_TICKS;
            pwm_period_reg    <= RST_PWM_PERIOD;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_TARGET_ANGLE:  target_angle_reg  <= cfg_data[15:0];
                CFG_GAIN_PROP:     gain_prop_reg     <= cfg_data[31:0];
                CFG_GAIN_INTEG:    gain_integ_reg    <= cfg_data[31:0];
                CFG_GAIN_DERIV:    gain_deriv_reg    <= cfg_data[31:0];
                CFG_STARTUP_TICKS: startup_ticks_reg <= cfg_data[15:0];
                CFG_PWM_PERIOD:    pwm_period_reg    <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

    pmd_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .angle_centideg (angle_centideg),
        .target_angle   (target_angle_reg),
        .startup_ticks  (startup_ticks_reg),
        .item           (front_item)
    );

    pmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_item),
        .not_empty (q_not_empty)
    );

    pmd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_not_empty),
        .item       (q_item),
        .pop        (q_pop),
        .gain_prop  (gain_prop_reg),
        .gain_integ (gain_integ_reg),
        .gain_deriv (gain_deriv_reg),
        .pwm_period (pwm_period_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .direction  (direction),
        .duty       (duty),
        .running    (running),
        .saturated  (saturated)
    );

endmodule

// File: rtl/pmd_front.sv
// Front end: counts control ticks, classifies them as idle or running and forms the error.
`timescale 1ns / 1ps

module pmd_front
    import pmd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic signed [15:0] angle_centideg,
    input  logic signed [15:0] target_angle,
    input  logic [15:0]        startup_ticks,
    output tick_item_t         item
);

    logic [15:0] tick_reg;
    logic [15:0] tick_next;

    // The counter advances before the startup compare and sticks at its maximum.
    assign tick_next = (tick_reg == 16'hFFFF) ? tick_reg : tick_reg + 16'd1;

    assign item.run = (tick_next >= startup_ticks);
    assign item.err = {target_angle[15], target_angle}
                    - {angle_centideg[15], angle_centideg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg <= 16'd0;
        end
        else if (push)
        begin
            tick_reg <= tick_next;
        end
    end

endmodule

// File: rtl/pmd_queue.sv
// Short item queue between the front end and the back end.
`timescale 1ns / 1ps

module pmd_queue
    import pmd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  tick_item_t push_item,
    output logic       full,
    input  logic       pop,
    output tick_item_t pop_item,
    output logic       not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    tick_item_t       slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue pushed while full");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !not_empty |-> !pop)
        else $error("queue popped while empty");

endmodule

// File: rtl/pmd_back.sv
// Back end: integrator with anti-windup, PID multiply and sum, saturation and duty scaling.
`timescale 1ns / 1ps

module pmd_back
    import pmd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  tick_item_t  item,
    output logic        pop,
    input  logic [31:0] gain_prop,
    input  logic [31:0] gain_integ,
    input  logic [31:0] gain_deriv,
    input  logic [15:0] pwm_period,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        direction,
    output logic [15:0] duty,
    output logic        running,
    output logic        saturated
);

    back_state_t st_reg;
    back_state_t st_next;

    // Controller state.
    logic signed [16:0] last_err_reg;
    logic signed [31:0] sum_reg;
    logic               was_sat_reg;

    // Per-item working registers.
    logic               run_reg;
    logic signed [16:0] e_reg;
    logic signed [17:0] diff_reg;
    logic signed [49:0] p_reg;
    logic signed [50:0] d_reg;
    logic signed [63:0] i_reg;
    logic signed [63:0] total_reg;

    fin_item_t fin_reg;
    logic      fin_valid_reg;
    logic      out_valid_reg;
    logic      dir_reg;
    logic [15:0] duty_reg;
    logic      run_out_reg;
    logic      sat_out_reg;

    logic               mag_done;
    logic               fin_move;
    logic               fin_free;
    logic               hold;
    logic               e_pos;
    logic               sum_pos;
    logic signed [32:0] sum_wide;
    logic signed [31:0] sum_next;
    logic signed [49:0] p_full;
    logic signed [50:0] d_full;
    logic signed [63:0] i_full;
    logic signed [63:0] i_clamp;
    logic signed [63:0] total_next;
    logic [63:0]        mag;
    fin_item_t          fin_next;
    logic [47:0]        duty_prod;

    assign fin_move = fin_valid_reg && (!out_valid_reg || out_ready);
    assign fin_free = !fin_valid_reg || fin_move;

    // Sequencer: next state.
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    st_next = ST_MUL;
                end
            end
            ST_MUL:  st_next = ST_ADD;
            ST_ADD:  st_next = ST_MAG;
            ST_MAG:
            begin
                if (fin_free)
                begin
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    // Sequencer: outputs.
    always_comb
    begin
        pop      = 1'b0;
        mag_done = 1'b0;
        case (st_reg)
            ST_IDLE: pop      = item_valid;
            ST_MAG:  mag_done = fin_free;
            default:
            begin
                pop      = 1'b0;
                mag_done = 1'b0;
            end
        endcase
    end

    // Integration is held while the last tick saturated and the error pushes the same way.
    assign e_pos    = !item.err[16] && (item.err != 17'sd0);
    assign sum_pos  = !sum_reg[31] && (sum_reg != 32'sd0);
    assign hold     = was_sat_reg && (e_pos == sum_pos);
    assign sum_wide = {sum_reg[31], sum_reg} + {{16{item.err[16]}}, item.err};

    always_comb
    begin
        if (sum_wide[32] != sum_wide[31])
        begin
            sum_next = sum_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            sum_next = sum_wide[31:0];
        end
    end

    assign p_full = $signed({1'b0, gain_prop}) * e_reg;
    assign d_full = $signed({1'b0, gain_deriv}) * diff_reg;
    // The product of a 32-bit gain and a 32-bit signed sum always fits in 64 signed bits.
    assign i_full = $signed({1'b0, gain_integ}) * sum_reg;

    always_comb
    begin
        if (i_reg > TERM_LIMIT)
        begin
            i_clamp = TERM_LIMIT;
        end
        else if (i_reg < -TERM_LIMIT)
        begin
            i_clamp = -TERM_LIMIT;
        end
        else
        begin
            i_clamp = i_reg;
        end
    end

    assign total_next = {{14{p_reg[49]}}, p_reg} + {{13{d_reg[50]}}, d_reg} + i_clamp;

    assign mag = total_reg[63] ? 64'(-total_reg) : 64'(total_reg);

    always_comb
    begin
        fin_next.run    = run_reg;
        fin_next.dir    = run_reg && !total_reg[63];
        fin_next.sat    = run_reg && (mag > FULL_DUTY_Q32);
        fin_next.full   = run_reg && (mag >= FULL_DUTY_Q32);
        fin_next.mag_lo = run_reg ? mag[31:0] : 32'd0;
    end

    assign duty_prod = fin_reg.mag_lo * pwm_period;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            last_err_reg  <= '0;
            sum_reg       <= '0;
            was_sat_reg   <= 1'b0;
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (pop && item.run)
            begin
                last_err_reg <= item.err;
                if (!hold)
                begin
                    sum_reg <= sum_next;
                end
            end
            if (mag_done && run_reg)
            begin
                was_sat_reg <= fin_next.sat;
            end
            if (mag_done)
            begin
                fin_valid_reg <= 1'b1;
            end
            else if (fin_move)
            begin
                fin_valid_reg <= 1'b0;
            end
            if (fin_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            run_reg  <= item.run;
            e_reg    <= item.err;
            diff_reg <= {item.err[16], item.err} - {last_err_reg[16], last_err_reg};
        end
        if (st_reg == ST_MUL)
        begin
            p_reg <= p_full;
            d_reg <= d_full;
            i_reg <= i_full;
        end
        if (st_reg == ST_ADD)
        begin
            total_reg <= total_next;
        end
        if (mag_done)
        begin
            fin_reg <= fin_next;
        end
        if (fin_move)
        begin
            dir_reg     <= fin_reg.dir;
            duty_reg    <= fin_reg.full ? pwm_period : duty_prod[47:32];
            run_out_reg <= fin_reg.run;
            sat_out_reg <= fin_reg.sat;
        end
    end

    assign out_valid = out_valid_reg;
    assign direction = dir_reg;
    assign duty      = duty_reg;
    assign running   = run_out_reg;
    assign saturated = sat_out_reg;

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> st_reg == ST_MUL)
        else $error("item taken outside the idle state");

    a_idle_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_valid_reg && !fin_reg.run) |-> (!fin_reg.dir && !fin_reg.sat && !fin_reg.full
            && fin_reg.mag_lo == 32'd0))
        else $error("idle tick carries a nonzero result");

    a_sat_update_source: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(was_sat_reg) |-> $past(mag_done && run_reg))
        else $error("saturation flag changed outside a running tick");

    a_sat_implies_full: assert property (@(posedge clk) disable iff (!rst_n)
        fin_valid_reg && fin_reg.sat |-> fin_reg.full)
        else $error("saturated result below full duty");

endmodule

// File: verif/tb_pid_motor_drive_antiwindup.sv
// Self-checking testbench for the PID motor drive with conditional-integration anti-windup.
`timescale 1ns / 1ps

module tb_pid_motor_drive_antiwindup;
    import pmd_pkg::*;

    typedef struct packed {
        logic        dir;
        logic [15:0] duty;
        logic        run;
        logic        sat;
    } drive_t;

    localparam longint SUM_MAX = 64'sd2147483647;
    localparam longint SUM_MIN = -64'sd2147483648;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [2:0]            cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic signed [15:0]    angle_centideg = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  direction;
    logic [15:0]           duty;
    logic                  running;
    logic                  saturated;

    pid_motor_drive_antiwindup uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .angle_centideg (angle_centideg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .direction      (direction),
        .duty           (duty),
        .running        (running),
        .saturated      (saturated)
    );

    // Shadow copy of the configuration registers.
    logic signed [15:0] target_cfg = RST_TARGET_ANGLE;
    logic [31:0]        kp_cfg = RST_GAIN_PROP;
    logic [31:0]        ki_cfg = RST_GAIN_INTEG;
    logic [31:0]        kd_cfg = RST_GAIN_DERIV;
    logic [15:0]        startup_cfg = RST_STARTUP_TICKS;
    logic [15:0]        period_cfg = RST_PWM_PERIOD;

    // Controller state as the predictor sees it.
    logic [15:0] tick_cnt = '0;
    int          prev_err = 0;
    int          integ_sum = 0;
    logic        sat_prev = 1'b0;

    logic signed [15:0] angle_queue[$];
    drive_t             expected_drive[$];
    logic signed [15:0] last_angle = '0;

    logic calm = 1'b0;
    logic hold_rx = 1'b0;
    int   send_gap = 0;
    int   recv_gap = 0;

    int mismatches = 0;
    int ticks_sent = 0;
    int idle_ticks = 0;
    int sat_ticks = 0;
    int hold_ticks = 0;
    int capped_terms = 0;
    int reg_writes = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #40_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic flag_mismatch(string msg);
        if (mismatches < 30)
            $display("tb: mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // One control tick: advances the predictor state and returns the drive it causes.
    function automatic drive_t control_tick(logic signed [15:0] ang);
        drive_t r;
        int     e;
        int     diff;
        longint sum_next;
        longint p_t;
        longint i_t;
        longint d_t;
        longint total;
        longint mag;
        longint scaled;
        r = '0;
        if (tick_cnt != 16'hFFFF)
            tick_cnt++;
        if (tick_cnt < startup_cfg) begin
            idle_ticks++;
            return r;
        end
        e = int'(target_cfg) - int'(ang);
        diff = e - prev_err;
        // The integrator is frozen while the last tick saturated and pushing the same way.
        if (sat_prev && ((e > 0) == (integ_sum > 0))) begin
            hold_ticks++;
        end
        else begin
            sum_next = longint'(integ_sum) + longint'(e);
            if (sum_next > SUM_MAX)
                integ_sum = int'(SUM_MAX);
            else if (sum_next < SUM_MIN)
                integ_sum = int'(SUM_MIN);
            else
                integ_sum = int'(sum_next);
        end
        p_t = longint'({32'd0, kp_cfg}) * longint'(e);
        d_t = longint'({32'd0, kd_cfg}) * longint'(diff);
        i_t = longint'({32'd0, ki_cfg}) * longint'(integ_sum);
        if (i_t > longint'(TERM_LIMIT)) begin
            i_t = longint'(TERM_LIMIT);
            capped_terms++;
        end
        else if (i_t < -longint'(TERM_LIMIT)) begin
            i_t = -longint'(TERM_LIMIT);
            capped_terms++;
        end
        total = p_t + i_t + d_t;
        mag = (total < 0) ? -total : total;
        r.sat = (mag > longint'(FULL_DUTY_Q32));
        if (mag >= longint'(FULL_DUTY_Q32)) begin
            r.duty = period_cfg;
        end
        else begin
            scaled = mag * longint'({48'd0, period_cfg});
            r.duty = 16'(scaled >> 32);
        end
        r.dir = (total >= 0);
        r.run = 1'b1;
        prev_err = e;
        sat_prev = r.sat;
        if (r.sat)
            sat_ticks++;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Mostly angles near the setpoint, so the loop stays in its linear range.
    function automatic logic signed [15:0] pick_angle();
        int a;
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            a = int'(target_cfg) + int'($urandom_range(0, 600)) - 300;
        else if (r < 80)
            a = int'($urandom_range(0, 36000)) - 18000;
        else if (r < 92)
            a = ($urandom_range(0, 1) == 1) ? 18000 : -18000;
        else
            a = int'(last_angle);
        if (a > 18000)
            a = 18000;
        if (a < -18000)
            a = -18000;
        last_angle = 16'(a);
        return 16'(a);
    endfunction

    function automatic logic [31:0] pick_gain();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2, 3, 4: return $urandom_range(0, 200000);
            5, 6, 7: return $urandom_range(1000000, 60000000);
            8: return $urandom;
            default: return $urandom_range(0, 2000);
        endcase
    endfunction

    // Sender: a new item is presented only once the previous one has been taken.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            angle_centideg <= '0;
            send_gap <= 0;
        end
        else if (!in_valid || in_ready) begin
            if (send_gap > 0) begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (angle_queue.size() != 0) begin
                in_valid <= 1'b1;
                angle_centideg <= angle_queue.pop_front();
                send_gap <= pick_gap();
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            recv_gap <= 0;
        end
        else if (hold_rx) begin
            out_ready <= 1'b0;
        end
        else if (recv_gap > 0) begin
            out_ready <= 1'b0;
            recv_gap <= recv_gap - 1;
        end
        else begin
            out_ready <= 1'b1;
            if (out_valid && out_ready)
                recv_gap <= pick_gap();
        end
    end

    // Monitor: predicts on each accepted item and checks each accepted result.
    always @(posedge clk) begin
        drive_t want;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                expected_drive.push_back(control_tick(angle_centideg));
                ticks_sent++;
            end
            if (out_valid && out_ready) begin
                if (expected_drive.size() == 0) begin
                    flag_mismatch("result arrived with nothing expected");
                end
                else begin
                    want = expected_drive.pop_front();
                    if (direction !== want.dir)
                        flag_mismatch($sformatf("direction %b, expected %b", direction, want.dir));
                    if (duty !== want.duty)
                        flag_mismatch($sformatf("duty %0d, expected %0d", duty, want.duty));
                    if (running !== want.run)
                        flag_mismatch($sformatf("running %b, expected %b", running, want.run));
                    if (saturated !== want.sat)
                        flag_mismatch($sformatf("saturated %b, expected %b", saturated, want.sat));
                end
            end
        end
    end

    // Long receiver hold-off once traffic is flowing, so the input queue fills and stalls.
    initial begin
        wait (ticks_sent >= 200);
        @(posedge clk);
        hold_rx <= 1'b1;
        repeat (150) @(posedge clk);
        hold_rx <= 1'b0;
    end

    task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        reg_writes++;
        case (idx)
            CFG_TARGET_ANGLE:  target_cfg = val[15:0];
            CFG_GAIN_PROP:     kp_cfg = val;
            CFG_GAIN_INTEG:    ki_cfg = val;
            CFG_GAIN_DERIV:    kd_cfg = val;
            CFG_STARTUP_TICKS: startup_cfg = val[15:0];
            CFG_PWM_PERIOD:    period_cfg = val[15:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(int tgt, logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
                                int startup, int period);
        write_reg(CFG_TARGET_ANGLE, 32'(tgt));
        write_reg(CFG_GAIN_PROP, kp);
        write_reg(CFG_GAIN_INTEG, ki);
        write_reg(CFG_GAIN_DERIV, kd);
        write_reg(CFG_STARTUP_TICKS, 32'(startup));
        write_reg(CFG_PWM_PERIOD, 32'(period));
    endtask

    task automatic offer(int a);
        angle_queue.push_back(16'(a));
    endtask

    // Waits until every item is sent and every result checked, then lets the pipe settle.
    task automatic drain();
        while (angle_queue.size() != 0 || in_valid || expected_drive.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic random_phase(int count, logic after_soak);
        int tgt;
        int startup;
        int period;
        int r;
        r = $urandom_range(0, 9);
        tgt = (r == 0) ? 18000 : (r == 1) ? -18000 : int'($urandom_range(0, 36000)) - 18000;
        if (after_soak)
            startup = ($urandom_range(0, 3) == 0) ? 65535 : int'($urandom_range(0, 65535));
        else if ($urandom_range(0, 2) == 0)
            startup = 0;
        else
            startup = int'(tick_cnt) + int'($urandom_range(0, 30));
        r = $urandom_range(0, 9);
        period = (r == 0) ? 1 : (r == 1) ? 65535 : int'($urandom_range(1, 65535));
        program_regs(tgt, pick_gain(), pick_gain(), pick_gain(), startup, period);
        calm = ($urandom_range(0, 3) == 0);
        @(negedge clk);
        repeat (count)
            offer(pick_angle());
        drain();
    endtask

    initial begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset defaults: still inside the startup delay, so these ticks idle.
        offer(0);
        offer(-18000);
        offer(18000);
        drain();

        // Saturation both ways, integration hold and release, zero error.
        program_regs(0, 32'h4000_0000, 32'd450, 32'd56220780, 0, 65535);
        @(negedge clk);
        offer(0);
        offer(-1);
        offer(-5);
        offer(-5);
        offer(3);
        offer(18000);
        offer(18000);
        offer(-18000);
        offer(4);
        offer(0);
        drain();

        // Output magnitude exactly at full duty, and the smallest nonzero period.
        program_regs(-18000, 32'h4000_0000, 32'd0, 32'd0, 0, 1);
        @(negedge clk);
        offer(-17996);
        offer(-18000);
        offer(-17997);
        offer(18000);
        offer(-17996);
        drain();

        // A zero period must give zero duty even when saturated.
        program_regs(0, 32'hFFFF_FFFF, 32'd450, 32'd56220780, 0, 0);
        @(negedge clk);
        offer(100);
        offer(-100);
        offer(0);
        drain();

        // Startup raised after the controller has run: back to idle ticks.
        write_reg(CFG_STARTUP_TICKS, 32'd65535);
        @(negedge clk);
        offer(18000);
        offer(-18000);
        offer(7);
        offer(-7);
        drain();

        repeat (3)
            random_phase(110, 1'b0);

        // Small gains keep the loop unsaturated while the integral builds up, back to back.
        program_regs(18000, 32'd100000, 32'd0, 32'd200000, 0, $urandom_range(1, 65535));
        calm = 1'b1;
        @(negedge clk);
        repeat (40)
            offer(int'($urandom_range(0, 2000)) - 18000);
        drain();

        // Full integral gain on the built-up sum drives the output far past full duty.
        program_regs(18000, 32'd0, 32'hFFFF_FFFF, 32'd0, 0, 65535);
        calm = 1'b0;
        @(negedge clk);
        offer(-18000);
        offer(-18000);
        offer(18000);
        offer(-17000);
        offer(0);
        drain();

        repeat (3)
            random_phase(100, 1'b1);

        $display("tb: %0d control ticks checked, %0d idle, %0d saturated outputs",
                 ticks_sent, idle_ticks, sat_ticks);
        $display("tb: %0d integration holds, %0d capped integral terms, %0d register writes",
                 hold_ticks, capped_terms, reg_writes);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
